// ===== hdl/vnorm_pkg.sv =====
// Package: shared widths, norm kinds, controller states and command/status structs.
`default_nettype none
package vnorm_pkg;

	localparam int ELEM_W = 24;   // element port width
	localparam int KIND_W = 2;    // action port width
	localparam int OUT_W  = 34;   // norm result width
	localparam int TOT_W  = 57;   // running total width

	typedef enum logic [KIND_W-1:0] {
		KIND_L1  = 2'd0,
		KIND_L2  = 2'd1,
		KIND_MAX = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_RUN  = 3'd0,
		S_FIN  = 3'd1,
		S_LOAD = 3'd2,
		S_ROOT = 3'd3,
		S_WAIT = 3'd4
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic take;
		logic sqrt_load;
		logic sqrt_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_last;
		logic kind_l2;
		logic root_done;
		logic out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/vnorm_elem_if.sv =====
// Interface: element input channel (valid/ready with element, last, action).
`default_nettype none
interface vnorm_elem_if;
	logic                             valid;
	logic                             ready;
	logic signed [vnorm_pkg::ELEM_W-1:0] element;
	logic                             last;
	logic [vnorm_pkg::KIND_W-1:0]     action;

	modport source (output valid, element, last, action, input ready);
	modport sink   (input valid, element, last, action, output ready);
endinterface
`default_nettype wire

// ===== hdl/vnorm_res_if.sv =====
// Interface: norm result channel (valid/ready with norm_value).
`default_nettype none
interface vnorm_res_if;
	logic                        valid;
	logic                        ready;
	logic [vnorm_pkg::OUT_W-1:0] norm_value;

	modport source (output valid, norm_value, input ready);
	modport sink   (input valid, norm_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/vector_norm_l1_l2_linf.sv =====
// Top level: vector norm engine (L1, L2, infinity) over Q7.16 element items.
//
//  channel | dir | handshake     | payload
//  elem    | in  | valid / ready | element[23:0] signed, last, action[1:0]
//  norm    | out | valid / ready | norm_value[33:0] unsigned Q.16
//
// One element item per cycle while a vector streams in.
// After the last item, L1 and infinity pass settle and load to the result register;
// L2 passes settle, root load, 29 root steps of the subtractor and load.
// A result waits in the output register; intake resumes once it is loaded.
// arst_n clears the controller, pipeline valid, vector flag and output valid.
`default_nettype none
module vector_norm_l1_l2_linf #(
	parameter int ELEM_WIDTH = 24
) (
	input wire logic    clk,
	input wire logic    arst_n,
	vnorm_elem_if.sink  elem,
	vnorm_res_if.source norm
);

	vnorm_pkg::ctrl_cmd_t cmd;
	vnorm_pkg::dp_sts_t   sts;

	vnorm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	vnorm_dp #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem),
		.norm   (norm),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
`default_nettype wire

// ===== hdl/vnorm_ctrl.sv =====
// Controller: sequences element intake, square root iterations and result hand-off.
`default_nettype none
module vnorm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vnorm_pkg::dp_sts_t  sts,
	output vnorm_pkg::ctrl_cmd_t     cmd
);

	vnorm_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vnorm_pkg::S_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			vnorm_pkg::S_RUN: begin
				cmd.in_ready = 1'b1;
				cmd.take     = sts.in_valid;
				if (sts.in_valid && sts.in_last) begin
					state_d = vnorm_pkg::S_FIN;
				end
			end
			vnorm_pkg::S_FIN: begin
				// last term lands in the total this cycle
				state_d = sts.kind_l2 ? vnorm_pkg::S_LOAD : vnorm_pkg::S_WAIT;
			end
			vnorm_pkg::S_LOAD: begin
				cmd.sqrt_load = 1'b1;
				state_d       = vnorm_pkg::S_ROOT;
			end
			vnorm_pkg::S_ROOT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.root_done) begin
					state_d = vnorm_pkg::S_WAIT;
				end
			end
			vnorm_pkg::S_WAIT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = vnorm_pkg::S_RUN;
				end
			end
			default: begin
				state_d = vnorm_pkg::S_RUN;
			end
		endcase
	end

	// root iterations only run for an L2 vector
	a_step_l2: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_step |-> sts.kind_l2)
		else $error("square root step outside an L2 vector");

	// the result register is never overwritten while still held
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result loaded while output slot busy");

	// intake stops right after the final element of a vector
	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && sts.in_last) |=> !cmd.in_ready)
		else $error("element taken after last before result finished");

endmodule
`default_nettype wire

// ===== hdl/vnorm_dp.sv =====
// Datapath: magnitude/square stage, saturating accumulator, bitwise root, result register.
`default_nettype none
module vnorm_dp #(
	parameter int ELEM_WIDTH = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	vnorm_elem_if.sink                elem,
	vnorm_res_if.source               norm,
	input  wire vnorm_pkg::ctrl_cmd_t cmd,
	output vnorm_pkg::dp_sts_t        sts
);

	localparam int TW = vnorm_pkg::TOT_W;
	localparam int OW = vnorm_pkg::OUT_W;
	localparam int SQ_W = 2 * ELEM_WIDTH;

	logic [ELEM_WIDTH-1:0] raw;
	logic [ELEM_WIDTH-1:0] mag;
	logic [SQ_W-1:0]       sq;
	vnorm_pkg::kind_t      kind_new, kind_use;

	logic                  valid_s1;
	logic                  first_s1;
	vnorm_pkg::kind_t      kind_s1;
	logic [TW-1:0]         term_s1;

	logic                  inside_q;
	vnorm_pkg::kind_t      kind_q;
	logic [TW-1:0]         total_q;
	logic [TW:0]           sum;
	logic [TW-1:0]         base;

	logic [TW-1:0]         x_q, r_q, bit_q;
	logic [TW:0]           rb;

	logic                  out_valid_q;
	logic [OW-1:0]         norm_q;
	logic [OW-1:0]         result;

	// magnitude of the low ELEM_WIDTH bits, then kind select
	assign raw = elem.element[ELEM_WIDTH-1:0];
	assign mag = raw[ELEM_WIDTH-1] ? (~raw + 1'b1) : raw;
	assign sq  = SQ_W'(mag) * SQ_W'(mag);

	always_comb begin
		case (elem.action)
			vnorm_pkg::KIND_L1: kind_new = vnorm_pkg::KIND_L1;
			vnorm_pkg::KIND_L2: kind_new = vnorm_pkg::KIND_L2;
			default:            kind_new = vnorm_pkg::KIND_MAX;
		endcase
	end
	assign kind_use = inside_q ? kind_q : kind_new;

	// stage 1: term register and vector bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			inside_q <= 1'b0;
			kind_q   <= vnorm_pkg::KIND_L1;
		end else begin
			valid_s1 <= cmd.take;
			if (cmd.take) begin
				inside_q <= !elem.last;
				kind_q   <= kind_use;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			first_s1 <= !inside_q;
			kind_s1  <= kind_use;
			term_s1  <= (kind_use == vnorm_pkg::KIND_L2) ? TW'(sq) : TW'(mag);
		end
	end

	// stage 2: saturating sum or running maximum; first element restarts
	assign base = first_s1 ? '0 : total_q;
	assign sum  = {1'b0, base} + {1'b0, term_s1};

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (kind_s1 == vnorm_pkg::KIND_MAX) begin
				total_q <= (term_s1 > base) ? term_s1 : base;
			end else begin
				total_q <= sum[TW] ? '1 : sum[TW-1:0];
			end
		end
	end

	// floored square root, one result bit per step
	assign rb = {1'b0, r_q} + {1'b0, bit_q};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			x_q   <= total_q;
			r_q   <= '0;
			bit_q <= TW'(1) << (TW - 1);
		end else if (cmd.sqrt_step) begin
			if ({1'b0, x_q} >= rb) begin
				x_q <= x_q - rb[TW-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// result select with output saturation
	always_comb begin
		if (kind_q == vnorm_pkg::KIND_L2) begin
			result = r_q[OW-1:0];
		end else if (|total_q[TW-1:OW]) begin
			result = '1;
		end else begin
			result = total_q[OW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (norm.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			norm_q <= result;
		end
	end

	assign norm.valid      = out_valid_q;
	assign norm.norm_value = norm_q;
	assign elem.ready      = cmd.in_ready;

	// status to the controller
	assign sts.in_valid  = elem.valid;
	assign sts.in_last   = elem.last;
	assign sts.kind_l2   = (kind_q == vnorm_pkg::KIND_L2);
	assign sts.root_done = bit_q[0];
	assign sts.out_busy  = out_valid_q && !norm.ready;

endmodule
`default_nettype wire

// ===== tb/vector_norm_l1_l2_linf_tb.sv =====
`timescale 1ns / 100ps
// Testbench: vector norm engine driven by a directed table and random vectors.
module vector_norm_l1_l2_linf_tb;

	localparam logic [vnorm_pkg::KIND_W-1:0] ACT_UNUSED  = 2'd3;  // spare action code, acts as infinity
	localparam logic [vnorm_pkg::TOT_W-1:0]  TOTAL_CAP   = '1;
	localparam logic [vnorm_pkg::OUT_W-1:0]  NORM_CAP    = '1;
	localparam int                           RAND_ITEMS  = 1000;
	localparam int                           CALM_FIRST  = 300;
	localparam int                           CALM_LAST   = 500;
	localparam int                           HOLD_AT     = 700;
	localparam int                           HOLD_CYCLES = 400;
	localparam int                           DRAIN_WAIT  = 64;
	localparam int                           CYCLE_LIMIT = 500000;
	localparam int                           NUM_ROWS    = 23;

	// one directed row: element repeated reps times, last only on the final repeat
	typedef struct packed {
		logic signed [vnorm_pkg::ELEM_W-1:0] element;
		logic                                last;
		logic [vnorm_pkg::KIND_W-1:0]        action;
		logic [15:0]                         reps;
		logic                                typed;
		logic [vnorm_pkg::OUT_W-1:0]         want;
	} row_t;

	logic clk;
	logic arst_n;

	vnorm_elem_if elem_ch ();
	vnorm_res_if  norm_ch ();

	vector_norm_l1_l2_linf u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_ch),
		.norm   (norm_ch)
	);

	// predictor state
	logic [vnorm_pkg::TOT_W-1:0]  acc_total;
	logic [vnorm_pkg::KIND_W-1:0] acc_kind;
	bit                           acc_open;

	logic [vnorm_pkg::OUT_W-1:0] pending_norms[$];
	int                          mismatch_count = 0;
	int                          cycle_count = 0;
	bit                          calm;
	bit                          hold_req;

	row_t dir_rows [0:NUM_ROWS-1];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// floored square root, one result bit at a time
	function automatic logic [vnorm_pkg::OUT_W-1:0] floor_root(
			input logic [vnorm_pkg::TOT_W-1:0] x);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int i = 28; i >= 0; i--) begin
			trial = r | (64'd1 << i);
			if (trial * trial <= {7'd0, x})
				r = trial;
		end
		return r[vnorm_pkg::OUT_W-1:0];
	endfunction

	// advance the norm state by one element; done marks a finished vector
	task automatic norm_predict(input logic signed [vnorm_pkg::ELEM_W-1:0] e, input logic l,
			input logic [vnorm_pkg::KIND_W-1:0] a, output bit done,
			output logic [vnorm_pkg::OUT_W-1:0] value);
		logic [vnorm_pkg::ELEM_W:0]  mag;
		logic [vnorm_pkg::TOT_W:0]   sum;
		logic [vnorm_pkg::TOT_W-1:0] raw;
		mag = e[vnorm_pkg::ELEM_W-1] ?
			(({1'b1, {vnorm_pkg::ELEM_W{1'b0}}}) - {1'b0, e}) : {1'b0, e};
		if (!acc_open) begin
			acc_kind  = a;
			acc_total = '0;
			acc_open  = 1'b1;
		end
		if (acc_kind == vnorm_pkg::KIND_L1) begin
			sum = acc_total + mag;
			acc_total = (sum > TOTAL_CAP) ? TOTAL_CAP : sum[vnorm_pkg::TOT_W-1:0];
		end else if (acc_kind == vnorm_pkg::KIND_L2) begin
			sum = acc_total + mag * mag;
			acc_total = (sum > TOTAL_CAP) ? TOTAL_CAP : sum[vnorm_pkg::TOT_W-1:0];
		end else if (mag > acc_total) begin
			acc_total = mag;
		end
		done  = l;
		value = '0;
		if (l) begin
			raw   = (acc_kind == vnorm_pkg::KIND_L2) ? floor_root(acc_total) : acc_total;
			value = (raw > NORM_CAP) ? NORM_CAP : raw[vnorm_pkg::OUT_W-1:0];
			acc_open = 1'b0;
		end
	endtask

	// offer one element until taken, then record what it should produce
	task automatic send_elem(input logic signed [vnorm_pkg::ELEM_W-1:0] e, input logic l,
			input logic [vnorm_pkg::KIND_W-1:0] a, input logic typed,
			input logic [vnorm_pkg::OUT_W-1:0] want);
		int                          gap;
		bit                          done;
		logic [vnorm_pkg::OUT_W-1:0] value;
		gap = (!calm && $urandom_range(99) < 13) ? $urandom_range(3, 1) : 0;
		repeat (gap) begin
			elem_ch.valid <= 1'b0;
			@(posedge clk);
		end
		elem_ch.valid   <= 1'b1;
		elem_ch.element <= e;
		elem_ch.last    <= l;
		elem_ch.action  <= a;
		do @(posedge clk); while (!elem_ch.ready);
		norm_predict(e, l, a, done, value);
		if (done)
			pending_norms.push_back(typed ? want : value);
	endtask

	// mix of extremes, small Q7.16 values and full-range noise
	function automatic logic signed [vnorm_pkg::ELEM_W-1:0] pick_element();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return 24'sh7FFFFF;
					1: return 24'sh800000;
					2: return 24'sh000000;
					3: return 24'sh000001;
					default: return 24'shFFFFFF;
				endcase
			end
			1, 2: return $signed(24'($urandom_range(524288))) - 24'sd262144;
			default: return r[vnorm_pkg::ELEM_W-1:0];
		endcase
	endfunction

	// result side: check each item, random ready, one long hold-off
	initial begin
		logic [vnorm_pkg::OUT_W-1:0] exp_norm;
		int                          hold_left;
		bit                          hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		norm_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (norm_ch.valid && norm_ch.ready) begin
				if (pending_norms.size() == 0) begin
					$error("norm_value: expected none, got %0d", norm_ch.norm_value);
					mismatch_count++;
				end else begin
					exp_norm = pending_norms.pop_front();
					if (norm_ch.norm_value !== exp_norm) begin
						$error("norm_value: expected %0d, got %0d", exp_norm, norm_ch.norm_value);
						mismatch_count++;
					end
				end
			end
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				norm_ch.ready <= 1'b0;
			end else if (calm) begin
				norm_ch.ready <= 1'b1;
			end else begin
				norm_ch.ready <= ($urandom_range(99) >= 13);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// stimulus
	initial begin
		int          len;
		logic [1:0]  act;
		calm            = 1'b0;
		hold_req        = 1'b0;
		acc_total       = '0;
		acc_kind        = vnorm_pkg::KIND_L1;
		acc_open        = 1'b0;
		arst_n          = 1'b0;
		elem_ch.valid   = 1'b0;
		elem_ch.element = '0;
		elem_ch.last    = 1'b0;
		elem_ch.action  = vnorm_pkg::KIND_L1;

		dir_rows = '{
			// single-element vectors: field extremes, zero, small values and bit patterns
			'{24'sd0,        1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd0},
			'{24'sd8388607,  1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd8388607},
			'{-24'sd8388608, 1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd8388608},
			'{-24'sd8388608, 1'b1, vnorm_pkg::KIND_L2,  16'd1, 1'b1, 34'd8388608},
			'{24'sd1,        1'b1, vnorm_pkg::KIND_L2,  16'd1, 1'b1, 34'd1},
			'{24'sd8388607,  1'b1, vnorm_pkg::KIND_MAX, 16'd1, 1'b1, 34'd8388607},
			'{24'sd0,        1'b1, vnorm_pkg::KIND_MAX, 16'd1, 1'b1, 34'd0},
			'{-24'sd5,       1'b1, ACT_UNUSED,          16'd1, 1'b1, 34'd5},
			'{-24'sd1,       1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd1},
			'{24'sh555555,   1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd5592405},
			'{24'shAAAAAA,   1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd5592406},
			// later actions are ignored
			'{24'sd65536,    1'b0, vnorm_pkg::KIND_L1,  16'd1, 1'b0, 34'd0},
			'{-24'sd65536,   1'b0, vnorm_pkg::KIND_L2,  16'd1, 1'b0, 34'd0},
			'{24'sd131072,   1'b1, vnorm_pkg::KIND_MAX, 16'd1, 1'b1, 34'd262144},
			'{24'sd3,        1'b0, vnorm_pkg::KIND_L2,  16'd1, 1'b0, 34'd0},
			'{-24'sd4,       1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd5},
			'{24'sd2,        1'b0, vnorm_pkg::KIND_MAX, 16'd1, 1'b0, 34'd0},
			'{-24'sd9,       1'b0, vnorm_pkg::KIND_L1,  16'd1, 1'b0, 34'd0},
			'{24'sd7,        1'b1, vnorm_pkg::KIND_L2,  16'd1, 1'b1, 34'd9},
			'{-24'sd100,     1'b0, ACT_UNUSED,          16'd1, 1'b0, 34'd0},
			'{24'sd50,       1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd100},
			// root rounds down: sqrt(50) -> 7
			'{24'sd5,        1'b0, vnorm_pkg::KIND_L2,  16'd1, 1'b0, 34'd0},
			'{-24'sd5,       1'b1, vnorm_pkg::KIND_L1,  16'd1, 1'b1, 34'd7}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].reps; k++) begin
				send_elem(dir_rows[i].element,
					dir_rows[i].last && (k == dir_rows[i].reps - 1),
					dir_rows[i].action, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// random vectors, mostly short
		for (int n = 0; n < RAND_ITEMS; ) begin
			case ($urandom_range(19))
				0: len = $urandom_range(300, 65);
				1, 2, 3, 4: len = $urandom_range(64, 9);
				default: len = $urandom_range(8, 1);
			endcase
			for (int k = 0; k < len; k++) begin
				calm = (n >= CALM_FIRST) && (n < CALM_LAST);
				if (n >= HOLD_AT)
					hold_req = 1'b1;
				act = $urandom_range(3);
				send_elem(pick_element(), k == len - 1, act, 1'b0, '0);
				n++;
			end
		end
		elem_ch.valid <= 1'b0;
		calm = 1'b0;

		while (pending_norms.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/vnorm_pkg.sv
hdl/vnorm_elem_if.sv
hdl/vnorm_res_if.sv
hdl/vnorm_ctrl.sv
hdl/vnorm_dp.sv
hdl/vector_norm_l1_l2_linf.sv
tb/vector_norm_l1_l2_linf_tb.sv
